>>> hw/rtl/isched_pkg.sv
// shared types and constants for the interval scheduler
package isched_pkg;

	localparam int HOUR_W         = 5;
	localparam int MINUTE_W       = 6;
	localparam int DUR_W          = 11;
	localparam int GAP_W          = 8;
	localparam int START_W        = 11;
	localparam int END_W          = 12;
	localparam int THR_W          = 13;
	localparam int COUNT_W        = 7;
	localparam int MINS_PER_HOUR  = 60;
	localparam int COUNT_MAX      = 127;
	localparam logic [GAP_W-1:0] GAP_RESET = 8'd10;

	typedef struct packed {
		logic load;
		logic init;
		logic issue;
		logic next_pass;
		logic clear;
	} isched_cmd_t;

	typedef struct packed {
		logic issue_last;
		logic found;
	} isched_sts_t;

endpackage

>>> hw/rtl/isched_dp.sv
// interval store, selection scan datapath and gap register
module isched_dp import isched_pkg::*; #(
	parameter int MAX_INTERVALS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  isched_cmd_t         cmd,
	output isched_sts_t         sts,
	input  logic [HOUR_W-1:0]   start_hour,
	input  logic [MINUTE_W-1:0] start_minute,
	input  logic [DUR_W-1:0]    duration,
	input  logic                cfg_we,
	input  logic [GAP_W-1:0]    cfg_data,
	output logic [COUNT_W-1:0]  chosen_count
);

	localparam int AW = $clog2(MAX_INTERVALS);
	localparam int CW = $clog2(MAX_INTERVALS + 1);
	localparam int MW = START_W + END_W;
	localparam int SW = CW + COUNT_W;

	logic [MW-1:0]      mem_q [MAX_INTERVALS];
	logic [MW-1:0]      rd_data_s1;
	logic [AW-1:0]      rd_idx_s1;
	logic               rd_valid_s1;
	logic [AW-1:0]      rd_addr_q;
	logic [CW-1:0]      loaded_q;
	logic               full;
	logic [START_W-1:0] start_val;
	logic [END_W-1:0]   end_val;
	logic [START_W-1:0] rd_start;
	logic [END_W-1:0]   rd_end;
	logic               after_last;
	logic               eligible;
	logic               better;
	logic               found_q;
	logic [END_W-1:0]   best_end_q;
	logic [AW-1:0]      best_idx_q;
	logic               have_last_q;
	logic [END_W-1:0]   last_end_q;
	logic [AW-1:0]      last_idx_q;
	logic [THR_W-1:0]   thr_q;
	logic [CW-1:0]      count_q;
	logic [GAP_W-1:0]   gap_q;
	logic [SW-1:0]      count_wide;

	assign full      = (loaded_q == CW'(MAX_INTERVALS));
	assign start_val = START_W'(START_W'(start_hour) * START_W'(MINS_PER_HOUR))
		+ START_W'(start_minute);
	assign end_val   = END_W'(start_val) + END_W'(duration);

	// interval store
	always_ff @(posedge clk) begin
		if (cmd.load && !full) begin
			mem_q[loaded_q[AW-1:0]] <= {end_val, start_val};
		end
		if (cmd.issue) begin
			rd_data_s1 <= mem_q[rd_addr_q];
			rd_idx_s1  <= rd_addr_q;
		end
	end

	assign rd_start = rd_data_s1[START_W-1:0];
	assign rd_end   = rd_data_s1[START_W +: END_W];

	// next in end order after the last taken one, starting at or after threshold
	assign after_last = !have_last_q || (rd_end > last_end_q)
		|| ((rd_end == last_end_q) && (rd_idx_s1 > last_idx_q));
	assign eligible   = rd_valid_s1 && after_last && (THR_W'(rd_start) >= thr_q);
	assign better     = !found_q || (rd_end < best_end_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q    <= '0;
			rd_addr_q   <= '0;
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
			best_end_q  <= '0;
			best_idx_q  <= '0;
			have_last_q <= 1'b0;
			last_end_q  <= '0;
			last_idx_q  <= '0;
			thr_q       <= '0;
			count_q     <= '0;
			gap_q       <= GAP_RESET;
		end else begin
			rd_valid_s1 <= cmd.issue;
			if (cfg_we) begin
				gap_q <= cfg_data;
			end
			if (cmd.clear) begin
				loaded_q <= '0;
			end else if (cmd.load && !full) begin
				loaded_q <= loaded_q + CW'(1);
			end
			if (cmd.init) begin
				rd_addr_q   <= '0;
				found_q     <= 1'b0;
				have_last_q <= 1'b0;
				thr_q       <= '0;
				count_q     <= '0;
			end else if (cmd.next_pass) begin
				rd_addr_q   <= '0;
				found_q     <= 1'b0;
				have_last_q <= 1'b1;
				last_end_q  <= best_end_q;
				last_idx_q  <= best_idx_q;
				thr_q       <= THR_W'(best_end_q) + THR_W'(gap_q);
				count_q     <= count_q + CW'(1);
			end else begin
				if (cmd.issue) begin
					rd_addr_q <= rd_addr_q + AW'(1);
				end
				if (eligible && better) begin
					found_q    <= 1'b1;
					best_end_q <= rd_end;
					best_idx_q <= rd_idx_s1;
				end
			end
		end
	end

	assign sts.issue_last = (rd_addr_q == AW'(loaded_q - CW'(1)));
	assign sts.found      = found_q;

	assign count_wide   = SW'(count_q);
	assign chosen_count = (count_wide > SW'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
		: count_wide[COUNT_W-1:0];

endmodule

>>> hw/rtl/isched_ctrl.sv
// controller state machine for loading and the selection passes
module isched_ctrl import isched_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        last_item,
	input  isched_sts_t sts,
	output isched_cmd_t cmd,
	output logic        busy,
	output logic        done
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	always_comb begin
		cmd.load      = start && !busy_q;
		cmd.init      = start && !busy_q && last_item;
		cmd.issue     = (state_q == ST_SCAN);
		cmd.next_pass = (state_q == ST_FINISH) && sts.found;
		cmd.clear     = (state_q == ST_FINISH) && !sts.found;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_FINISH) && !sts.found;
			unique case (state_q)
				ST_IDLE: begin
					if (start && last_item) begin
						state_q <= ST_SCAN;
						busy_q  <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (sts.issue_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (sts.found) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

>>> hw/rtl/interval_schedule_max_count.sv
// top level of the interval scheduler: max count of gapped non-overlapping intervals
// loading: one interval per cycle while busy is low, busy stays low after a request without last_item
// on last_item: k+1 scan passes over n stored intervals, k taken, each pass reading every stored interval in turn,
// bounded by one store read port; done pulses in the first cycle that busy reads low
// the receiver cannot stall: chosen_count is valid in the single cycle done is high
// asynchronous active-low reset empties the store and sets the gap to ten minutes
module interval_schedule_max_count import isched_pkg::*; #(
	parameter int MAX_INTERVALS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [HOUR_W-1:0]   start_hour,
	input  logic [MINUTE_W-1:0] start_minute,
	input  logic [DUR_W-1:0]    duration,
	input  logic                last_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [GAP_W-1:0]    cfg_data,
	output logic                done,
	output logic [COUNT_W-1:0]  chosen_count
);

	isched_cmd_t cmd;
	isched_sts_t sts;

	assign cfg_ready = 1'b1;

	isched_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.last_item (last_item),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	isched_dp #(
		.MAX_INTERVALS (MAX_INTERVALS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.start_hour   (start_hour),
		.start_minute (start_minute),
		.duration     (duration),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.chosen_count (chosen_count)
	);

endmodule

>>> hw/rtl/isched_chk.sv
// port-level checker for the interval scheduler, bound to the top level
module isched_chk import isched_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                last_item,
	input logic                done,
	input logic [COUNT_W-1:0]  chosen_count
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && !$isunknown(chosen_count)))
		else $error("result strobe while busy or with unknown count");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_item) |=> busy)
		else $error("last request did not start the computation");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !last_item) |=> !busy)
		else $error("plain load request made the block busy");

	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("computation ended without a result");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

endmodule

bind interval_schedule_max_count isched_chk u_isched_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.last_item    (last_item),
	.done         (done),
	.chosen_count (chosen_count)
);
